// File: rtl/fxalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q24.8 ALU package
// Shared types and constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;
   localparam int FracBits = 8;
   localparam int DataW    = 32;
   localparam int QDepth   = 4;
   localparam int QPtrW    = $clog2(QDepth);

   typedef enum logic [3:0] {
      MODE_ADD      = 4'd0,
      MODE_SUB      = 4'd1,
      MODE_MUL      = 4'd2,
      MODE_DIV      = 4'd3,
      MODE_CMP      = 4'd4,
      MODE_MIN      = 4'd5,
      MODE_MAX      = 4'd6,
      MODE_INC      = 4'd7,
      MODE_DEC      = 4'd8,
      MODE_FROM_INT = 4'd9,
      MODE_TO_INT   = 4'd10
   } mode_type;

   // Classified item handed from the front part to the back part.
   typedef struct packed {
      logic [3:0]              mode;
      logic signed [DataW-1:0] a;
      logic signed [DataW-1:0] b;
      logic                    gt;
      logic                    lt;
      logic                    eq;
      logic                    b_zero;
   } op_type;

   typedef struct packed {
      logic signed [DataW-1:0] value;
      logic                    gt;
      logic                    lt;
      logic                    eq;
      logic                    dz;
      logic                    sat;
   } res_type;
endpackage

// File: rtl/fixed_point_q24_8_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU
// Queue-style signed Q24.8 ALU: add, sub, mul, div, compare, min/max and more.
// ----------------------------------------------------------------------------
// One item enters per cycle while full is low; the pipeline length is set by
// the divider, which resolves one quotient bit of the 40-bit scaled dividend
// per pipeline stage. All modes travel the same pipeline, so results leave
// in push order. The front end classifies items into a four-entry op queue;
// the back end holds a result queue with credit flow control, so full rises
// only when results pile up unread. Compare flags are valid for every mode.
module fixed_point_q24_8_alu_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [3:0]                         req_mode,
   input  logic signed [fxalu_pkg::DataW-1:0] req_operand_a,
   input  logic signed [fxalu_pkg::DataW-1:0] req_operand_b,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [fxalu_pkg::DataW-1:0] rsp_result_value,
   output logic                               rsp_a_greater,
   output logic                               rsp_a_less,
   output logic                               rsp_a_equal,
   output logic                               rsp_divide_by_zero,
   output logic                               rsp_saturated
);
   import fxalu_pkg::*;

   logic    in_ready, q_valid, q_ready, out_valid;
   op_type  q_op;
   res_type res;

   // Classify and queue items.
   fxalu_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(push), .in_ready(in_ready),
      .in_mode(req_mode), .in_a(req_operand_a), .in_b(req_operand_b),
      .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
   );

   // Execute and hold results.
   fxalu_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
      .out_valid(out_valid), .out_ready(pop), .out_res(res)
   );

   assign full               = !in_ready;
   assign empty              = !out_valid;
   assign rsp_result_value   = res.value;
   assign rsp_a_greater      = res.gt;
   assign rsp_a_less         = res.lt;
   assign rsp_a_equal        = res.eq;
   assign rsp_divide_by_zero = res.dz;
   assign rsp_saturated      = res.sat;

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      !empty |-> $onehot({rsp_a_greater, rsp_a_less, rsp_a_equal}))
      else $error("compare flags not exclusive");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty) else $error("result lost");
   a_sat_val: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_saturated |-> rsp_result_value == 32'sh7fffffff ||
      rsp_result_value == 32'sh80000000) else $error("bad clamp value");
endmodule

// File: rtl/fxalu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q24.8 ALU front end
// Accept items, compute compare flags, push into the op queue.
// ----------------------------------------------------------------------------
module fxalu_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [3:0]                        in_mode,
   input  logic signed [fxalu_pkg::DataW-1:0] in_a,
   input  logic signed [fxalu_pkg::DataW-1:0] in_b,
   output logic                              q_valid,
   input  logic                              q_ready,
   output fxalu_pkg::op_type                 q_op
);
   import fxalu_pkg::*;

   op_type                mem [QDepth];
   logic [QPtrW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [QPtrW:0]        cnt_ff, cnt_in;
   op_type                op_w;
   logic                  push_w, pop_w;

   always_comb begin
      op_w.mode   = in_mode;
      op_w.a      = in_a;
      op_w.b      = in_b;
      op_w.gt     = in_a > in_b;
      op_w.lt     = in_a < in_b;
      op_w.eq     = in_a == in_b;
      op_w.b_zero = in_b == '0;
   end

   assign in_ready = cnt_ff != (QPtrW+1)'(QDepth);
   assign push_w   = in_valid && in_ready;
   assign q_valid  = cnt_ff != '0;
   assign pop_w    = q_valid && q_ready;
   assign q_op     = mem[rd_ptr_ff];
   assign cnt_in   = cnt_ff + (QPtrW+1)'(push_w) - (QPtrW+1)'(pop_w);

   always_ff @(posedge clock) begin
      if (push_w) mem[wr_ptr_ff] <= op_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push_w) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop_w)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPtrW+1)'(QDepth)) else $error("op queue overflow");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      push_w && !pop_w |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count");
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !pop_w) else $error("pop from empty queue");
endmodule

// File: rtl/fxalu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q24.8 ALU back end
// Execute pipeline: 40-step restoring divider, registered multiply, result queue.
// ----------------------------------------------------------------------------
module fxalu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  fxalu_pkg::op_type    q_op,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fxalu_pkg::res_type   out_res
);
   import fxalu_pkg::*;

   localparam int NumW   = DataW + FracBits;   // dividend magnitude width
   localparam int Stages = NumW;               // one quotient bit per stage
   localparam int Lat    = Stages + 2;
   localparam int OQD    = 64;                 // >= Lat + 1
   localparam int OPW    = $clog2(OQD);

   // Pipeline stage state
   op_type               op_ff   [Stages+1];
   logic                 v_ff    [Stages+1];
   logic [NumW-1:0]      quo_ff  [Stages+1];
   logic [DataW:0]       rem_ff  [Stages+1];
   logic [DataW-1:0]     dmag_ff [Stages+1];
   logic                 neg_ff  [Stages+1];
   logic signed [2*DataW-1:0] prod_ff;
   res_type              fin_ff;
   res_type              fin_in_w;
   logic                 fin_v_ff;

   // Result queue
   res_type              oq [OQD];
   logic [OPW-1:0]       owr_ff, ord_ff, ord_in;
   logic [OPW:0]         ocnt_ff, credit_ff;
   logic                 take_w, opop_w;
   res_type              head_ff;

   // Credits count in-flight plus stored results so the queue never overflows.
   assign q_ready = credit_ff < (OPW+1)'(OQD);
   assign take_w  = q_valid && q_ready;
   assign opop_w  = out_valid && out_ready;

   function automatic logic [DataW-1:0] absv(input logic signed [DataW-1:0] x);
      absv = x[DataW-1] ? (DataW)'(-x) : x;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Stages; i++) v_ff[i] <= 1'b0;
         fin_v_ff <= 1'b0;
      end else begin
         v_ff[0] <= take_w;
         for (int i = 1; i <= Stages; i++) v_ff[i] <= v_ff[i-1];
         fin_v_ff <= v_ff[Stages];
      end
   end

   // Stage 0 loads magnitudes; each later stage does one restoring step.
   always_ff @(posedge clock) begin
      op_ff[0]   <= q_op;
      quo_ff[0]  <= {absv(q_op.a), (FracBits)'(0)};
      rem_ff[0]  <= '0;
      dmag_ff[0] <= absv(q_op.b);
      neg_ff[0]  <= q_op.a[DataW-1] ^ q_op.b[DataW-1];
      for (int i = 1; i <= Stages; i++) begin
         logic [DataW+1:0] t;
         t = {rem_ff[i-1], quo_ff[i-1][NumW-1]} - {2'b0, dmag_ff[i-1]};
         op_ff[i]   <= op_ff[i-1];
         dmag_ff[i] <= dmag_ff[i-1];
         neg_ff[i]  <= neg_ff[i-1];
         if (!t[DataW+1]) begin
            rem_ff[i] <= t[DataW:0];
            quo_ff[i] <= {quo_ff[i-1][NumW-2:0], 1'b1};
         end else begin
            rem_ff[i] <= {rem_ff[i-1][DataW-1:0], quo_ff[i-1][NumW-1]};
            quo_ff[i] <= {quo_ff[i-1][NumW-2:0], 1'b0};
         end
      end
   end

   // Multiplier: one 32x32 product registered, delayed to align at the end.
   logic signed [2*DataW-1:0] pd_ff [Stages];
   always_ff @(posedge clock) begin
      pd_ff[0] <= q_op.a * q_op.b;
      for (int i = 1; i < Stages; i++) pd_ff[i] <= pd_ff[i-1];
      prod_ff <= pd_ff[Stages-1];
   end

   // Final stage: select and saturate.
   always_comb begin
      op_type o;
      logic signed [2*DataW-1:0] ps;
      logic [NumW:0]             qs;
      logic signed [NumW:0]      qv;
      res_type r;
      o  = op_ff[Stages];
      ps = prod_ff >>> FracBits;
      qs = {1'b0, quo_ff[Stages]};
      qv = neg_ff[Stages] ? -$signed(qs) : $signed(qs);
      r.gt = o.gt; r.lt = o.lt; r.eq = o.eq; r.dz = 1'b0; r.sat = 1'b0;
      r.value = '0;
      case (o.mode)
         MODE_ADD:      r.value = o.a + o.b;
         MODE_SUB:      r.value = o.a - o.b;
         MODE_MUL: begin
            if (ps > 64'sd2147483647) begin
               r.value = 32'h7fffffff; r.sat = 1'b1;
            end else if (ps < -64'sd2147483648) begin
               r.value = 32'h80000000; r.sat = 1'b1;
            end else r.value = ps[DataW-1:0];
         end
         MODE_DIV: begin
            if (o.b_zero) begin
               r.dz = 1'b1;
            end else if (qv > (NumW+1)'(64'sd2147483647)) begin
               r.value = 32'h7fffffff; r.sat = 1'b1;
            end else if (qv < $signed(-(NumW+1)'(64'sd2147483648))) begin
               r.value = 32'h80000000; r.sat = 1'b1;
            end else r.value = qv[DataW-1:0];
         end
         MODE_MIN:      r.value = (o.lt || o.eq) ? o.a : o.b;
         MODE_MAX:      r.value = (o.gt || o.eq) ? o.a : o.b;
         MODE_INC:      r.value = o.a + 1;
         MODE_DEC:      r.value = o.a - 1;
         MODE_FROM_INT: r.value = o.a <<< FracBits;
         MODE_TO_INT:   r.value = o.a >>> FracBits;
         default:       r.value = '0;
      endcase
      fin_in_w = r;
   end

   always_ff @(posedge clock) fin_ff <= fin_in_w;

   always_ff @(posedge clock) begin
      if (fin_v_ff) oq[owr_ff] <= fin_ff;
   end

   // Read the head entry one address ahead; bypass an entry written this cycle.
   assign ord_in = ord_ff + (OPW)'(opop_w);

   always_ff @(posedge clock) begin
      if (fin_v_ff && owr_ff == ord_in) head_ff <= fin_ff;
      else head_ff <= oq[ord_in];
   end

   assign out_valid = ocnt_ff != '0;
   assign out_res   = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff <= '0; ord_ff <= '0; ocnt_ff <= '0; credit_ff <= '0;
      end else begin
         if (fin_v_ff) owr_ff <= owr_ff + 1'b1;
         if (opop_w)   ord_ff <= ord_ff + 1'b1;
         ocnt_ff   <= ocnt_ff + (OPW+1)'(fin_v_ff) - (OPW+1)'(opop_w);
         credit_ff <= credit_ff + (OPW+1)'(take_w) - (OPW+1)'(opop_w);
      end
   end

   a_credit: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= credit_ff) else $error("result count exceeds credits");
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (OPW+1)'(OQD)) else $error("result queue overflow");
   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      fin_v_ff && fin_ff.dz |-> !fin_ff.sat) else $error("dz with saturation");
endmodule
